// ===== rtl/core/sbl_pkg.sv =====
// Shared widths, codes and types of the sprite sheet blitter.
package sbl_pkg;

   localparam int SBL_MAX_SPRITE_WIDTH  = 8;
   localparam int SBL_MAX_SPRITE_HEIGHT = 8;
   localparam int SBL_SHEET_DEPTH       = 4096;

   localparam int SBL_DIM_W     = 4;
   localparam int SBL_ADDR_W    = 12;
   localparam int SBL_VALUE_W   = 9;
   localparam int SBL_COORD_W   = 16;
   localparam int SBL_FRAME_W   = 6;
   localparam int SBL_COLOR_W   = 8;
   localparam int SBL_IDX_W     = 17;
   localparam int SBL_CSR_IDX_W = 3;

   localparam logic [SBL_DIM_W-1:0] SBL_GRID_MAX = 4'd15;

   localparam logic SBL_ACT_WRITE = 1'b0;
   localparam logic SBL_ACT_DRAW  = 1'b1;

   typedef enum logic [SBL_CSR_IDX_W-1:0] {
      CSR_SPRITE_WIDTH  = 3'd0,
      CSR_SPRITE_HEIGHT = 3'd1,
      CSR_FRAMES_ACROSS = 3'd2,
      CSR_FRAMES_DOWN   = 3'd3
   } sbl_csr_idx_type;

   typedef struct packed {
      logic [SBL_DIM_W-1:0] sprite_width;
      logic [SBL_DIM_W-1:0] sprite_height;
      logic [SBL_DIM_W-1:0] frames_across;
      logic [SBL_DIM_W-1:0] frames_down;
   } sbl_cfg_type;

endpackage

// ===== rtl/core/sbl_if.sv =====
// Handshake channels of the sprite sheet blitter: request, response and register write.
interface sbl_req_if;
   import sbl_pkg::*;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [SBL_ADDR_W-1:0]         sheet_address;
   logic signed [SBL_VALUE_W-1:0] sheet_value;
   logic signed [SBL_COORD_W-1:0] origin_x;
   logic signed [SBL_COORD_W-1:0] origin_y;
   logic [SBL_FRAME_W-1:0]        frame_number;

   modport source (output valid, action, sheet_address, sheet_value, origin_x, origin_y,
                   frame_number, input ready);
   modport sink   (input valid, action, sheet_address, sheet_value, origin_x, origin_y,
                   frame_number, output ready);
endinterface

interface sbl_rsp_if;
   import sbl_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SBL_COORD_W-1:0] pixel_x;
   logic signed [SBL_COORD_W-1:0] pixel_y;
   logic [SBL_COLOR_W-1:0]        pixel_color;
   logic                          last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

interface sbl_csr_if;
   import sbl_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [SBL_CSR_IDX_W-1:0] index;
   logic [SBL_DIM_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sbl_ram.sv =====
// Generic simple dual-port RAM with registered read.
module sbl_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sbl_div.sv =====
// Restoring divider, one quotient bit per cycle: frame number by frames across.
module sbl_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sbl_pkg::SBL_FRAME_W-1:0] dividend,
   input  logic [sbl_pkg::SBL_DIM_W-1:0]   divisor,
   output logic                          done,
   output logic [sbl_pkg::SBL_FRAME_W-1:0] quotient,
   output logic [sbl_pkg::SBL_DIM_W-1:0]   remainder
);
   import sbl_pkg::*;

   localparam int CNT_W = $clog2(SBL_FRAME_W);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SBL_FRAME_W-1:0] quo_ff, quo_in;
   logic [SBL_DIM_W-1:0]   rem_ff, rem_in;
   logic [SBL_DIM_W:0]     trial;
   logic                   fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[SBL_FRAME_W-1]};
      fits    = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? SBL_DIM_W'(trial - {1'b0, divisor}) : trial[SBL_DIM_W-1:0];
         quo_in = {quo_ff[SBL_FRAME_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SBL_FRAME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/sbl_draw.sv =====
// Request sequencer: sheet writes, frame address setup and the read-and-emit walk.
module sbl_draw #(
   parameter int MAX_SPRITE_WIDTH  = sbl_pkg::SBL_MAX_SPRITE_WIDTH,
   parameter int MAX_SPRITE_HEIGHT = sbl_pkg::SBL_MAX_SPRITE_HEIGHT,
   parameter int SHEET_DEPTH       = sbl_pkg::SBL_SHEET_DEPTH,
   localparam int AW = $clog2(SHEET_DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   sbl_req_if.sink                           req_chan,
   sbl_rsp_if.source                         rsp_chan,
   input  sbl_pkg::sbl_cfg_type              cfg,
   output logic                              mem_wr_en,
   output logic [AW-1:0]                     mem_wr_addr,
   output logic [sbl_pkg::SBL_VALUE_W-1:0]   mem_wr_data,
   output logic                              mem_rd_en,
   output logic [AW-1:0]                     mem_rd_addr,
   input  logic [sbl_pkg::SBL_VALUE_W-1:0]   mem_rd_data
);
   import sbl_pkg::*;

   localparam logic [SBL_DIM_W-1:0] W_TOP =
      (MAX_SPRITE_WIDTH >= 15) ? SBL_GRID_MAX : SBL_DIM_W'(MAX_SPRITE_WIDTH);
   localparam logic [SBL_DIM_W-1:0] H_TOP =
      (MAX_SPRITE_HEIGHT >= 15) ? SBL_GRID_MAX : SBL_DIM_W'(MAX_SPRITE_HEIGHT);
   localparam logic [SBL_IDX_W-1:0] DEPTH_LIM = SBL_IDX_W'(SHEET_DEPTH);

   typedef enum logic [2:0] {
      IDLE, CLAMP, DIVIDE, MUL_A, MUL_B, WALK, DRAIN, FLUSH
   } state_type;

   function automatic logic [SBL_DIM_W-1:0] clamp_dim(input logic [SBL_DIM_W-1:0] v,
                                                      input logic [SBL_DIM_W-1:0] top);
      logic [SBL_DIM_W-1:0] r;
      if (v == '0) begin
         r = 4'd1;
      end else begin
         r = (v > top) ? top : v;
      end
      return r;
   endfunction

   state_type                state_ff, state_in;
   logic [SBL_COORD_W-1:0]   origin_x_ff, origin_x_in;
   logic [SBL_COORD_W-1:0]   origin_y_ff, origin_y_in;
   logic [SBL_FRAME_W-1:0]   frame_ff, frame_in;
   logic [7:0]               stride_ff, stride_in;
   logic [9:0]               hrow_ff, hrow_in;
   logic [7:0]               wcol_ff, wcol_in;
   logic [SBL_IDX_W-1:0]     addr_ff, addr_in;
   logic [SBL_IDX_W-1:0]     row_addr_ff, row_addr_in;
   logic [SBL_DIM_W-1:0]     px_ff, px_in;
   logic [SBL_DIM_W-1:0]     py_ff, py_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_inrange_ff, s1_inrange_in;
   logic [SBL_DIM_W-1:0]     s1_px_ff, s1_px_in;
   logic [SBL_DIM_W-1:0]     s1_py_ff, s1_py_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [SBL_COORD_W-1:0]   pend_x_ff, pend_x_in;
   logic [SBL_COORD_W-1:0]   pend_y_ff, pend_y_in;
   logic [SBL_COLOR_W-1:0]   pend_color_ff, pend_color_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SBL_COORD_W-1:0]   rsp_x_ff, rsp_x_in;
   logic [SBL_COORD_W-1:0]   rsp_y_ff, rsp_y_in;
   logic [SBL_COLOR_W-1:0]   rsp_color_ff, rsp_color_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [SBL_DIM_W-1:0]     w, h, fa, fd;
   logic [7:0]               last_frame;
   logic [SBL_FRAME_W-1:0]   frame_clamped;
   logic                     accept;
   logic                     out_free;
   logic                     visible;
   logic                     stall;
   logic                     issue;
   logic                     inrange;
   logic [17:0]              base_full;
   logic [SBL_IDX_W-1:0]     row_next;
   logic                     div_done;
   logic [SBL_FRAME_W-1:0]   div_quo;
   logic [SBL_DIM_W-1:0]     div_rem;

   sbl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == CLAMP),
      .dividend  (frame_clamped),
      .divisor   (fa),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      w  = clamp_dim(cfg.sprite_width, W_TOP);
      h  = clamp_dim(cfg.sprite_height, H_TOP);
      fa = clamp_dim(cfg.frames_across, SBL_GRID_MAX);
      fd = clamp_dim(cfg.frames_down, SBL_GRID_MAX);

      last_frame    = ({4'b0, fa} * {4'b0, fd}) - 8'd1;
      frame_clamped = ({2'b0, frame_ff} > last_frame) ? last_frame[SBL_FRAME_W-1:0] : frame_ff;

      accept   = req_chan.valid && (state_ff == IDLE);
      out_free = !rsp_valid_ff || rsp_chan.ready;
      visible  = s1_valid_ff && s1_inrange_ff && !mem_rd_data[SBL_VALUE_W-1];
      // a visible pixel must push the held one out; wait when the output is full
      stall    = visible && pend_valid_ff && !out_free;
      issue    = (state_ff == WALK) && !stall;
      inrange  = addr_ff < DEPTH_LIM;
      base_full = ({10'b0, stride_ff} * {8'b0, hrow_ff}) + {10'b0, wcol_ff};
      row_next  = row_addr_ff + SBL_IDX_W'(stride_ff);

      mem_wr_en   = accept && (req_chan.action == SBL_ACT_WRITE) &&
                    (SBL_IDX_W'(req_chan.sheet_address) < DEPTH_LIM);
      mem_wr_addr = AW'(req_chan.sheet_address);
      mem_wr_data = req_chan.sheet_value;
      mem_rd_en   = issue && inrange;
      mem_rd_addr = AW'(addr_ff);

      state_in      = state_ff;
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      frame_in      = frame_ff;
      stride_in     = stride_ff;
      hrow_in       = hrow_ff;
      wcol_in       = wcol_ff;
      addr_in       = addr_ff;
      row_addr_in   = row_addr_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      s1_valid_in   = s1_valid_ff;
      s1_inrange_in = s1_inrange_ff;
      s1_px_in      = s1_px_ff;
      s1_py_in      = s1_py_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_color_in = pend_color_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_last_in   = rsp_last_ff;

      // retire the read in flight: hold a visible pixel until the next one shows up
      if (s1_valid_ff && !stall) begin
         s1_valid_in = 1'b0;
         if (visible) begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pend_x_ff;
               rsp_y_in     = pend_y_ff;
               rsp_color_in = pend_color_ff;
               rsp_last_in  = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_x_in     = origin_x_ff + SBL_COORD_W'(s1_px_ff);
            pend_y_in     = origin_y_ff + SBL_COORD_W'(s1_py_ff);
            pend_color_in = mem_rd_data[SBL_COLOR_W-1:0];
         end
      end

      case (state_ff)
         IDLE: begin
            if (accept && (req_chan.action == SBL_ACT_DRAW)) begin
               origin_x_in = req_chan.origin_x;
               origin_y_in = req_chan.origin_y;
               frame_in    = req_chan.frame_number;
               state_in    = CLAMP;
            end
         end
         CLAMP: begin
            state_in = DIVIDE;
         end
         DIVIDE: begin
            if (div_done) begin
               state_in = MUL_A;
            end
         end
         MUL_A: begin
            stride_in = {4'b0, w} * {4'b0, fa};
            hrow_in   = {6'b0, h} * {4'b0, div_quo};
            wcol_in   = {4'b0, w} * {4'b0, div_rem};
            state_in  = MUL_B;
         end
         MUL_B: begin
            addr_in     = SBL_IDX_W'(base_full);
            row_addr_in = SBL_IDX_W'(base_full);
            px_in       = '0;
            py_in       = '0;
            state_in    = WALK;
         end
         WALK: begin
            if (issue) begin
               s1_valid_in   = 1'b1;
               s1_inrange_in = inrange;
               s1_px_in      = px_ff;
               s1_py_in      = py_ff;
               if (px_ff == w - 1'b1) begin
                  px_in       = '0;
                  py_in       = py_ff + 1'b1;
                  row_addr_in = row_next;
                  addr_in     = row_next;
                  if (py_ff == h - 1'b1) begin
                     state_in = DRAIN;
                  end
               end else begin
                  px_in   = px_ff + 1'b1;
                  addr_in = addr_ff + 1'b1;
               end
            end
         end
         DRAIN: begin
            if (!s1_valid_ff) begin
               state_in = FLUSH;
            end
         end
         FLUSH: begin
            // send the held pixel as the closing item of the draw
            if (!pend_valid_ff) begin
               state_in = IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = pend_x_ff;
               rsp_y_in      = pend_y_ff;
               rsp_color_in  = pend_color_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         s1_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         s1_valid_ff   <= s1_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      origin_x_ff   <= origin_x_in;
      origin_y_ff   <= origin_y_in;
      frame_ff      <= frame_in;
      stride_ff     <= stride_in;
      hrow_ff       <= hrow_in;
      wcol_ff       <= wcol_in;
      addr_ff       <= addr_in;
      row_addr_ff   <= row_addr_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      s1_inrange_ff <= s1_inrange_in;
      s1_px_ff      <= s1_px_in;
      s1_py_ff      <= s1_py_in;
      pend_x_ff     <= pend_x_in;
      pend_y_ff     <= pend_y_in;
      pend_color_ff <= pend_color_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_chan.ready       = (state_ff == IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_x     = rsp_x_ff;
   assign rsp_chan.pixel_y     = rsp_y_ff;
   assign rsp_chan.pixel_color = rsp_color_ff;
   assign rsp_chan.last_pixel  = rsp_last_ff;

endmodule

// ===== rtl/core/sprite_sheet_blitter.sv =====
// Sprite sheet blitter: a sheet RAM of frames, drawn as a stream of visible pixels.
// A write item stores one sheet entry. A draw item clamps its frame number, divides it
// by frames across in a bit-serial divider (six quotient steps), forms the frame's base
// address in the MUL_A and MUL_B states and then reads one sheet entry per cycle from the
// single read port of the sheet RAM while no visible pixel stalls on a full response
// register; the block takes no new request until the draw is done.
// Entries with the sign bit set are transparent and produce no item; the final item of a
// draw carries last_pixel, and a draw with nothing visible produces no item. The sheet
// RAM is not cleared: entries read before being written return undefined colors.
module sprite_sheet_blitter #(
   parameter int MAX_SPRITE_WIDTH  = sbl_pkg::SBL_MAX_SPRITE_WIDTH,
   parameter int MAX_SPRITE_HEIGHT = sbl_pkg::SBL_MAX_SPRITE_HEIGHT,
   parameter int SHEET_DEPTH       = sbl_pkg::SBL_SHEET_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   sbl_req_if.sink   req_chan,
   sbl_rsp_if.source rsp_chan,
   sbl_csr_if.sink   csr_chan
);
   import sbl_pkg::*;

   localparam int AW = $clog2(SHEET_DEPTH);

   logic [SBL_DIM_W-1:0] width_ff, width_in;
   logic [SBL_DIM_W-1:0] height_ff, height_in;
   logic [SBL_DIM_W-1:0] across_ff, across_in;
   logic [SBL_DIM_W-1:0] down_ff, down_in;
   sbl_cfg_type          cfg;

   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [SBL_VALUE_W-1:0] mem_wr_data;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [SBL_VALUE_W-1:0] mem_rd_data;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      across_in = across_ff;
      down_in   = down_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SPRITE_WIDTH:  width_in  = csr_chan.data;
            CSR_SPRITE_HEIGHT: height_in = csr_chan.data;
            CSR_FRAMES_ACROSS: across_in = csr_chan.data;
            CSR_FRAMES_DOWN:   down_in   = csr_chan.data;
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 4'd1;
         height_ff <= 4'd1;
         across_ff <= 4'd1;
         down_ff   <= 4'd1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         across_ff <= across_in;
         down_ff   <= down_in;
      end
   end

   assign csr_chan.ready    = 1'b1;
   assign cfg.sprite_width  = width_ff;
   assign cfg.sprite_height = height_ff;
   assign cfg.frames_across = across_ff;
   assign cfg.frames_down   = down_ff;

   sbl_ram #(
      .WIDTH (SBL_VALUE_W),
      .DEPTH (SHEET_DEPTH)
   ) u_sheet (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sbl_draw #(
      .MAX_SPRITE_WIDTH  (MAX_SPRITE_WIDTH),
      .MAX_SPRITE_HEIGHT (MAX_SPRITE_HEIGHT),
      .SHEET_DEPTH       (SHEET_DEPTH)
   ) u_draw (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .cfg         (cfg),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule
